>>> hw/rtl/greedy_box_coalescer_top_assert.svh
// Assertion macros used by the checker file of the box coalescer.
`ifndef GREEDY_BOX_COALESCER_TOP_ASSERT_SVH
`define GREEDY_BOX_COALESCER_TOP_ASSERT_SVH

// Property checked at every rising clock edge, switched off while reset is high.
`define GBC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every rising clock edge, reset included.
`define GBC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/gbc_pkg.sv
package gbc_pkg;

   localparam int MAX_REGIONS = 16;
   localparam int IDX_W       = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
   localparam int COORD_W     = 32;
   localparam int SIZE_W      = 31;
   localparam int DROP_W      = 8;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [DROP_W-1:0] DROP_MAX = {DROP_W{1'b1}};

   // Register index, taken from address bit 2 (one 32-bit word per register).
   localparam logic REG_SIDE_LIMIT = 1'b0;

   typedef struct packed {
      logic signed [COORD_W-1:0] min_x;
      logic signed [COORD_W-1:0] min_y;
      logic signed [COORD_W-1:0] min_z;
      logic [SIZE_W-1:0]         size_x;
      logic [SIZE_W-1:0]         size_y;
      logic [SIZE_W-1:0]         size_z;
   } box_type;

   typedef struct packed {
      box_type box;
      logic    fit;
   } union_res_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT_RD,
      ST_EMIT_LD
   } state_type;

endpackage

>>> hw/rtl/gbc_table.sv
module gbc_table (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [gbc_pkg::IDX_W-1:0]       wr_addr,
   input  gbc_pkg::box_type                wr_data,
   input  logic [gbc_pkg::IDX_W-1:0]       rd_addr,
   output gbc_pkg::box_type                rd_data
);

   gbc_pkg::box_type mem [gbc_pkg::MAX_REGIONS];
   gbc_pkg::box_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/gbc_union.sv
module gbc_union (
   input  logic                              clock,
   input  logic                              load,
   input  gbc_pkg::box_type                  entry,
   input  gbc_pkg::box_type                  item,
   input  logic [gbc_pkg::SIZE_W-1:0]        side_limit,
   output gbc_pkg::union_res_type            res
);

   localparam logic signed [gbc_pkg::COORD_W-1:0] POS_MAX =
      {1'b0, {(gbc_pkg::COORD_W-1){1'b1}}};

   // End of a box along one axis, cut at the largest coordinate.
   function automatic logic signed [gbc_pkg::COORD_W-1:0] sat_end(
      input logic signed [gbc_pkg::COORD_W-1:0] lo,
      input logic [gbc_pkg::SIZE_W-1:0]         sz
   );
      logic signed [gbc_pkg::COORD_W:0] sum;
      sum = $signed({lo[gbc_pkg::COORD_W-1], lo})
            + $signed({2'b00, sz});
      if (!sum[gbc_pkg::COORD_W] && sum[gbc_pkg::COORD_W-1]) begin
         sat_end = POS_MAX;
      end else begin
         sat_end = sum[gbc_pkg::COORD_W-1:0];
      end
   endfunction

   logic signed [gbc_pkg::COORD_W-1:0] a_min [3];
   logic signed [gbc_pkg::COORD_W-1:0] b_min [3];
   logic [gbc_pkg::SIZE_W-1:0]         a_sz  [3];
   logic [gbc_pkg::SIZE_W-1:0]         b_sz  [3];

   logic signed [gbc_pkg::COORD_W-1:0] lo_in [3];
   logic signed [gbc_pkg::COORD_W-1:0] ea_in [3];
   logic signed [gbc_pkg::COORD_W-1:0] eb_in [3];
   logic signed [gbc_pkg::COORD_W-1:0] lo_ff [3];
   logic signed [gbc_pkg::COORD_W-1:0] ea_ff [3];
   logic signed [gbc_pkg::COORD_W-1:0] eb_ff [3];

   logic signed [gbc_pkg::COORD_W-1:0] hi    [3];
   logic signed [gbc_pkg::COORD_W:0]   width [3];
   logic [2:0]                         axis_fit;

   assign a_min[0] = entry.min_x;
   assign a_min[1] = entry.min_y;
   assign a_min[2] = entry.min_z;
   assign a_sz[0]  = entry.size_x;
   assign a_sz[1]  = entry.size_y;
   assign a_sz[2]  = entry.size_z;
   assign b_min[0] = item.min_x;
   assign b_min[1] = item.min_y;
   assign b_min[2] = item.min_z;
   assign b_sz[0]  = item.size_x;
   assign b_sz[1]  = item.size_y;
   assign b_sz[2]  = item.size_z;

   // First half: smaller minimum and both saturated ends.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         lo_in[k] = (a_min[k] < b_min[k]) ? a_min[k] : b_min[k];
         ea_in[k] = sat_end(a_min[k], a_sz[k]);
         eb_in[k] = sat_end(b_min[k], b_sz[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         lo_ff <= lo_in;
         ea_ff <= ea_in;
         eb_ff <= eb_in;
      end
   end

   // Second half: larger end, union width and the limit check.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         hi[k]       = (ea_ff[k] > eb_ff[k]) ? ea_ff[k] : eb_ff[k];
         width[k]    = $signed({hi[k][gbc_pkg::COORD_W-1], hi[k]})
                       - $signed({lo_ff[k][gbc_pkg::COORD_W-1], lo_ff[k]});
         axis_fit[k] = $unsigned(width[k]) <= {2'b00, side_limit};
      end
      res.fit        = &axis_fit;
      res.box.min_x  = lo_ff[0];
      res.box.min_y  = lo_ff[1];
      res.box.min_z  = lo_ff[2];
      res.box.size_x = width[0][gbc_pkg::SIZE_W-1:0];
      res.box.size_y = width[1][gbc_pkg::SIZE_W-1:0];
      res.box.size_z = width[2][gbc_pkg::SIZE_W-1:0];
   end

endmodule

>>> hw/rtl/greedy_box_coalescer_top.sv
// Greedy box coalescer. Each accepted item is an axis-aligned 3D box (signed Q16.16
// minimum corner and unsigned Q15.16 size); it is merged into the first stored box
// whose union with it has no side longer than the side limit, appended to the table
// if no box fits, or dropped and counted in a saturating 8-bit tally if the table of
// 16 boxes is already full. The item that carries in_last is processed first, then
// every stored box leaves on the rsp_ channel in table order, the final one with
// out_last set, and the table is emptied; the drop tally is cleared only by reset.
// Items are taken one at a time: the table is scanned through one shared union
// unit fed by a single registered read port. Each stored box passes the read port
// register and then the union unit's register before it is decided; the scan
// stops at the first fit or after the last stored box, and an empty table fits
// nothing at once. At a batch end each box is read out of the table and then
// loaded into the output register once that register is free. The output
// register lets the last emitted box wait for the consumer while the next item is
// already accepted. The side limit sits at byte address 0 of the APB-style port
// and should only be written while the block is idle.
module greedy_box_coalescer_top (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [gbc_pkg::COORD_W-1:0]  req_in_min_x,
   input  logic signed [gbc_pkg::COORD_W-1:0]  req_in_min_y,
   input  logic signed [gbc_pkg::COORD_W-1:0]  req_in_min_z,
   input  logic [gbc_pkg::SIZE_W-1:0]          req_in_size_x,
   input  logic [gbc_pkg::SIZE_W-1:0]          req_in_size_y,
   input  logic [gbc_pkg::SIZE_W-1:0]          req_in_size_z,
   input  logic                                req_in_last,

   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [gbc_pkg::COORD_W-1:0]  rsp_out_min_x,
   output logic signed [gbc_pkg::COORD_W-1:0]  rsp_out_min_y,
   output logic signed [gbc_pkg::COORD_W-1:0]  rsp_out_min_z,
   output logic [gbc_pkg::SIZE_W-1:0]          rsp_out_size_x,
   output logic [gbc_pkg::SIZE_W-1:0]          rsp_out_size_y,
   output logic [gbc_pkg::SIZE_W-1:0]          rsp_out_size_z,
   output logic                                rsp_out_last,
   output logic [gbc_pkg::DROP_W-1:0]          rsp_dropped_count,

   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [gbc_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [gbc_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [gbc_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   // Control state.
   gbc_pkg::state_type               state_ff, state_in;
   logic [gbc_pkg::CNT_W-1:0]        count_ff, count_in;
   logic [gbc_pkg::DROP_W-1:0]       drop_ff, drop_in;
   logic [gbc_pkg::SIZE_W-1:0]       side_limit_ff, side_limit_in;
   logic [gbc_pkg::CNT_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic                             s1_vld_ff, s1_vld_in;
   logic [gbc_pkg::CNT_W-1:0]        s1_idx_ff, s1_idx_in;
   logic                             s2_vld_ff, s2_vld_in;
   logic [gbc_pkg::CNT_W-1:0]        s2_idx_ff, s2_idx_in;
   logic [gbc_pkg::CNT_W-1:0]        emit_idx_ff, emit_idx_in;
   logic                             out_vld_ff, out_vld_in;

   // Payload registers.
   gbc_pkg::box_type                 item_ff, item_in;
   logic                             last_ff, last_in;
   gbc_pkg::box_type                 out_ff, out_in;
   logic                             out_last_ff, out_last_in;
   logic [gbc_pkg::DROP_W-1:0]       out_drop_ff, out_drop_in;

   // Table and union unit connections.
   logic                             wr_en;
   logic [gbc_pkg::IDX_W-1:0]        wr_addr;
   gbc_pkg::box_type                 wr_data;
   logic [gbc_pkg::IDX_W-1:0]        rd_addr;
   gbc_pkg::box_type                 rd_data;
   gbc_pkg::union_res_type           ures;

   logic                             csr_wr;
   logic                             hit;
   logic                             no_fit;
   logic                             emit_last;

   gbc_table u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   gbc_union u_union (
      .clock      (clock),
      .load       (s1_vld_ff),
      .entry      (rd_data),
      .item       (item_ff),
      .side_limit (side_limit_ff),
      .res        (ures)
   );

   // Configuration port: one register, always ready.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[2] == gbc_pkg::REG_SIDE_LIMIT);
   assign csr_prdata = (csr_paddr[2] == gbc_pkg::REG_SIDE_LIMIT)
                       ? {1'b0, side_limit_ff} : '0;
   assign side_limit_in = csr_wr ? csr_pwdata[gbc_pkg::SIZE_W-1:0] : side_limit_ff;

   assign req_ready = (state_ff == gbc_pkg::ST_IDLE);

   // A box that reaches the second union stage either fits, or, being the last
   // stored box, tells us that nothing fits. An empty table fits nothing at once.
   assign hit       = s2_vld_ff && ures.fit;
   assign no_fit    = (count_ff == '0)
                      || (s2_vld_ff && !ures.fit
                          && (gbc_pkg::CNT_W'(s2_idx_ff + 1'b1) == count_ff));
   assign emit_last = (gbc_pkg::CNT_W'(emit_idx_ff + 1'b1) == count_ff);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      drop_in     = drop_ff;
      rd_ptr_in   = rd_ptr_ff;
      s1_vld_in   = 1'b0;
      s1_idx_in   = s1_idx_ff;
      s2_vld_in   = 1'b0;
      s2_idx_in   = s2_idx_ff;
      emit_idx_in = emit_idx_ff;
      item_in     = item_ff;
      last_in     = last_ff;
      out_in      = out_ff;
      out_last_in = out_last_ff;
      out_drop_in = out_drop_ff;
      out_vld_in  = out_vld_ff && !rsp_ready;
      wr_en       = 1'b0;
      wr_addr     = s2_idx_ff[gbc_pkg::IDX_W-1:0];
      wr_data     = ures.box;
      rd_addr     = rd_ptr_ff[gbc_pkg::IDX_W-1:0];

      unique case (state_ff)
         gbc_pkg::ST_IDLE: begin
            if (req_valid) begin
               item_in.min_x  = req_in_min_x;
               item_in.min_y  = req_in_min_y;
               item_in.min_z  = req_in_min_z;
               item_in.size_x = req_in_size_x;
               item_in.size_y = req_in_size_y;
               item_in.size_z = req_in_size_z;
               last_in        = req_in_last;
               rd_ptr_in      = '0;
               state_in       = gbc_pkg::ST_SCAN;
            end
         end

         gbc_pkg::ST_SCAN: begin
            // One read issued per cycle; each result passes the read and union registers.
            if (rd_ptr_ff < count_ff) begin
               s1_vld_in = 1'b1;
               s1_idx_in = rd_ptr_ff;
               rd_ptr_in = gbc_pkg::CNT_W'(rd_ptr_ff + 1'b1);
            end
            s2_vld_in = s1_vld_ff;
            s2_idx_in = s1_idx_ff;

            if (hit || no_fit) begin
               if (hit) begin
                  wr_en = 1'b1;
               end else if (count_ff < gbc_pkg::CNT_W'(gbc_pkg::MAX_REGIONS)) begin
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[gbc_pkg::IDX_W-1:0];
                  wr_data  = item_ff;
                  count_in = gbc_pkg::CNT_W'(count_ff + 1'b1);
               end else if (drop_ff != gbc_pkg::DROP_MAX) begin
                  drop_in = gbc_pkg::DROP_W'(drop_ff + 1'b1);
               end
               s1_vld_in   = 1'b0;
               s2_vld_in   = 1'b0;
               emit_idx_in = '0;
               state_in    = last_ff ? gbc_pkg::ST_EMIT_RD : gbc_pkg::ST_IDLE;
            end
         end

         gbc_pkg::ST_EMIT_RD: begin
            rd_addr  = emit_idx_ff[gbc_pkg::IDX_W-1:0];
            state_in = gbc_pkg::ST_EMIT_LD;
         end

         gbc_pkg::ST_EMIT_LD: begin
            rd_addr = emit_idx_ff[gbc_pkg::IDX_W-1:0];
            if (!out_vld_ff || rsp_ready) begin
               out_in      = rd_data;
               out_last_in = emit_last;
               out_drop_in = drop_ff;
               out_vld_in  = 1'b1;
               if (emit_last) begin
                  count_in = '0;
                  state_in = gbc_pkg::ST_IDLE;
               end else begin
                  emit_idx_in = gbc_pkg::CNT_W'(emit_idx_ff + 1'b1);
                  state_in    = gbc_pkg::ST_EMIT_RD;
               end
            end
         end

         default: begin
            state_in = gbc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= gbc_pkg::ST_IDLE;
         count_ff      <= '0;
         drop_ff       <= '0;
         side_limit_ff <= '0;
         s1_vld_ff     <= 1'b0;
         s2_vld_ff     <= 1'b0;
         out_vld_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         drop_ff       <= drop_in;
         side_limit_ff <= side_limit_in;
         s1_vld_ff     <= s1_vld_in;
         s2_vld_ff     <= s2_vld_in;
         out_vld_ff    <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff   <= rd_ptr_in;
      s1_idx_ff   <= s1_idx_in;
      s2_idx_ff   <= s2_idx_in;
      emit_idx_ff <= emit_idx_in;
      item_ff     <= item_in;
      last_ff     <= last_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
      out_drop_ff <= out_drop_in;
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_out_min_x     = out_ff.min_x;
   assign rsp_out_min_y     = out_ff.min_y;
   assign rsp_out_min_z     = out_ff.min_z;
   assign rsp_out_size_x    = out_ff.size_x;
   assign rsp_out_size_y    = out_ff.size_y;
   assign rsp_out_size_z    = out_ff.size_z;
   assign rsp_out_last      = out_last_ff;
   assign rsp_dropped_count = out_drop_ff;

endmodule

>>> hw/rtl/gbc_checker.sv
`include "greedy_box_coalescer_top_assert.svh"

module gbc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_out_last,
   input logic [gbc_pkg::DROP_W-1:0]    rsp_dropped_count
);

   // A result item held back by the consumer keeps its marker and tally.
   `GBC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_last) && $stable(rsp_dropped_count), "result item changed while stalled")

   // Every item keeps the block busy for at least the cycle after it is taken.
   `GBC_ASSERT(a_busy_after_accept, clock, reset, req_valid && req_ready |=> !req_ready, "input accepted back to back")

   // While a batch is still being read out, no new item may enter.
   `GBC_ASSERT(a_no_accept_mid_batch, clock, reset, rsp_valid && !rsp_out_last |-> !req_ready, "input ready before batch end was emitted")

   // Reset leaves the block idle with nothing to deliver.
   `GBC_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> req_ready && !rsp_valid, "block not idle after reset")

endmodule

bind greedy_box_coalescer_top gbc_checker u_gbc_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_out_last      (rsp_out_last),
   .rsp_dropped_count (rsp_dropped_count)
);
